// File: design/ibus_rc_frame_decoder_top_defines.svh
// Assertion macros shared by the frame decoder files.
`ifndef IBUS_RC_FRAME_DECODER_TOP_DEFINES_SVH
`define IBUS_RC_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define IBRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ibrc: assertion failed");

`define IBRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibrc: assertion failed");

`else

`define IBRC_ASSERT(lbl, clk, rst, prop)
`define IBRC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: design/ibrc_pkg.sv
package ibrc_pkg;

   localparam int NumChan   = 10;
   localparam int ChanBytes = 2 * NumChan;
   localparam int FrameLen  = 32;
   localparam int SumLowPos = 30;
   localparam int LastPos   = FrameLen - 1;
   localparam int PosW      = $clog2(FrameLen);
   localparam int ChanIdxW  = $clog2(ChanBytes);
   localparam int MidDepth  = 2;

   localparam logic [7:0]  HdrFirst  = 8'h20;
   localparam logic [7:0]  HdrSecond = 8'h40;
   localparam logic [15:0] SumStart  = 16'hFFFF;

   typedef logic [NumChan-1:0][15:0] chan_vec_type;

   // channel 9 first: 9..0
   localparam chan_vec_type ChanReset = {
      16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1000,
      16'd1000, 16'd1500, 16'd1000, 16'd1500, 16'd1500
   };

   typedef enum logic [2:0] {
      CLASS_HUNT,
      CLASS_HDR2,
      CLASS_BODY,
      CLASS_SUM_LOW,
      CLASS_LAST
   } byte_class_type;

   typedef struct packed {
      logic         bad;
      chan_vec_type chan;
   } frame_entry_type;

endpackage

// File: design/ibrc_front.sv
`include "ibus_rc_frame_decoder_top_defines.svh"

module ibrc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [7:0]               req_rx_byte,
   input  logic                     q_full,
   output logic                     q_push,
   output ibrc_pkg::frame_entry_type q_data
);
   import ibrc_pkg::*;

   logic [PosW-1:0]     pos_ff, pos_in;
   logic [15:0]         sum_ff, sum_in;
   logic [7:0]          sum_low_ff, sum_low_in;
   logic [7:0]          chan_bytes_ff [ChanBytes];
   logic [ChanIdxW-1:0] chan_idx;
   logic                chan_we;
   logic                accept;
   logic [15:0]         got;
   byte_class_type      byte_class;

   always_comb begin
      priority if (pos_ff == PosW'(0)) begin
         byte_class = CLASS_HUNT;
      end else if (pos_ff == PosW'(1)) begin
         byte_class = CLASS_HDR2;
      end else if (pos_ff < PosW'(SumLowPos)) begin
         byte_class = CLASS_BODY;
      end else if (pos_ff == PosW'(SumLowPos)) begin
         byte_class = CLASS_SUM_LOW;
      end else begin
         byte_class = CLASS_LAST;
      end
   end

   // only the closing byte needs a queue slot
   assign req_full = (byte_class == CLASS_LAST) && q_full;
   assign accept   = req_push && !req_full;
   assign chan_idx = ChanIdxW'(pos_ff - PosW'(2));
   assign got      = {req_rx_byte, sum_low_ff};

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      sum_low_in = sum_low_ff;
      chan_we    = 1'b0;
      q_push     = 1'b0;
      if (accept) begin
         unique case (byte_class)
            CLASS_HUNT: begin
               if (req_rx_byte == HdrFirst) begin
                  sum_in = SumStart - 16'(req_rx_byte);
                  pos_in = PosW'(1);
               end
            end
            CLASS_HDR2: begin
               if (req_rx_byte != HdrSecond) begin
                  pos_in = '0;
               end else begin
                  sum_in = sum_ff - 16'(req_rx_byte);
                  pos_in = pos_ff + PosW'(1);
               end
            end
            CLASS_BODY: begin
               chan_we = (chan_idx < ChanIdxW'(ChanBytes));
               sum_in  = sum_ff - 16'(req_rx_byte);
               pos_in  = pos_ff + PosW'(1);
            end
            CLASS_SUM_LOW: begin
               sum_low_in = req_rx_byte;
               pos_in     = pos_ff + PosW'(1);
            end
            CLASS_LAST: begin
               q_push = 1'b1;
               pos_in = '0;
               sum_in = SumStart;
            end
            default: begin
               pos_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      q_data.bad = (got != sum_ff);
      for (int i = 0; i < NumChan; i++) begin
         q_data.chan[i] = {chan_bytes_ff[2*i+1], chan_bytes_ff[2*i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= SumStart;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
      sum_low_ff <= sum_low_in;
      if (chan_we) begin
         chan_bytes_ff[chan_idx] <= req_rx_byte;
      end
   end

   `IBRC_ASSERT(a_full_on_last, clock, reset, req_full |-> (pos_ff == PosW'(LastPos)))
   `IBRC_ASSERT_NEXT(a_frame_wrap, clock, reset, q_push, (pos_ff == '0) && (sum_ff == SumStart))
   `IBRC_ASSERT_NEXT(a_hunt_noise, clock, reset,
      accept && (pos_ff == '0) && (req_rx_byte != HdrFirst), pos_ff == '0)

endmodule

// File: design/ibrc_fifo.sv
`include "ibus_rc_frame_decoder_top_defines.svh"

module ibrc_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `IBRC_ASSERT(a_count_bound, clock, reset, count_ff <= CntW'(Depth))

endmodule

// File: design/ibrc_back.sv
`include "ibus_rc_frame_decoder_top_defines.svh"

module ibrc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  ibrc_pkg::frame_entry_type q_data,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_frame_status,
   output ibrc_pkg::chan_vec_type    rsp_chan
);
   import ibrc_pkg::*;

   chan_vec_type held_ff, held_in;
   chan_vec_type out_chan_ff, out_chan_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_status_ff, out_status_in;

   // take a frame when the result slot is free or drains this cycle
   assign q_pop = !q_empty && (!out_valid_ff || rsp_pop);

   always_comb begin
      held_in       = held_ff;
      out_chan_in   = out_chan_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      if (q_pop) begin
         out_valid_in  = 1'b1;
         out_status_in = q_data.bad;
         if (!q_data.bad) begin
            held_in     = q_data.chan;
            out_chan_in = q_data.chan;
         end else begin
            out_chan_in = held_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= ChanReset;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
      out_chan_ff   <= out_chan_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_chan         = out_chan_ff;

   // a waiting result always shows the channels as held after its frame
   `IBRC_ASSERT(a_out_matches_held, clock, reset, out_valid_ff |-> (out_chan_ff == held_ff))

endmodule

// File: design/ibus_rc_frame_decoder_top.sv
// iBUS frame decoder. Feed one received serial byte per beat on req_*; the
// block takes a byte every cycle while req_full is low. req_full rises only
// while the closing byte of a frame is due and the frame queue (FrameQueueDepth
// entries, default two) between the byte framer and the result stage is full.
// Each completed 32-byte frame gives one result beat on rsp_*, via the frame
// queue and then the result register: frame_status 0 when the checksum
// matched and the ten channels were updated, 1 when it failed and the held
// channels are repeated. Channels come up at their failsafe values after reset.
module ibus_rc_frame_decoder_top #(
   parameter int FrameQueueDepth = ibrc_pkg::MidDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_frame_status,
   output logic [15:0] rsp_chan0,
   output logic [15:0] rsp_chan1,
   output logic [15:0] rsp_chan2,
   output logic [15:0] rsp_chan3,
   output logic [15:0] rsp_chan4,
   output logic [15:0] rsp_chan5,
   output logic [15:0] rsp_chan6,
   output logic [15:0] rsp_chan7,
   output logic [15:0] rsp_chan8,
   output logic [15:0] rsp_chan9
);
   import ibrc_pkg::*;

   localparam int EntryW = $bits(frame_entry_type);

   logic            fq_push, fq_full, fq_pop, fq_empty;
   frame_entry_type fq_in, fq_out;
   logic [EntryW-1:0] fq_out_bits;
   chan_vec_type    chan;

   ibrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .q_full      (fq_full),
      .q_push      (fq_push),
      .q_data      (fq_in)
   );

   ibrc_fifo #(
      .Width (EntryW),
      .Depth (FrameQueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_out_bits),
      .empty     (fq_empty)
   );

   assign fq_out = frame_entry_type'(fq_out_bits);

   ibrc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (fq_empty),
      .q_data           (fq_out),
      .q_pop            (fq_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_status (rsp_frame_status),
      .rsp_chan         (chan)
   );

   assign rsp_chan0 = chan[0];
   assign rsp_chan1 = chan[1];
   assign rsp_chan2 = chan[2];
   assign rsp_chan3 = chan[3];
   assign rsp_chan4 = chan[4];
   assign rsp_chan5 = chan[5];
   assign rsp_chan6 = chan[6];
   assign rsp_chan7 = chan[7];
   assign rsp_chan8 = chan[8];
   assign rsp_chan9 = chan[9];

endmodule
